FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// An antecedent that must be followed by a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ASSERT_IMPLY(label, ante, cons, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

FILE: hdl/fud_pkg.sv
// ----------------------------------------------------------------------------
// File URI percent decoder package
// Shared types, constants and character helpers of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fud_pkg;

  // Length of the "file://" prefix and the escape character.
  localparam int unsigned PrefixLen = 7;
  localparam logic [7:0] PctChar = 8'h25;

  // Number of decoded bytes one request can carry after its prefix bytes.
  localparam int unsigned TailMax = 3;

  // Work handed from the front part to the back part for one request.
  typedef struct packed {
    logic [2:0]              pfx_cnt;   // leading prefix bytes to replay
    logic [TailMax-1:0][7:0] tail;      // decoded bytes after them
    logic [1:0]              tail_cnt;  // number of valid tail bytes
    logic                    last;      // request closes the string
  } cmd_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Byte of "file://" at a given position.
  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h66;  // f
      3'd1:    b = 8'h69;  // i
      3'd2:    b = 8'h6c;  // l
      3'd3:    b = 8'h65;  // e
      3'd4:    b = 8'h3a;  // :
      3'd5:    b = 8'h2f;  // /
      3'd6:    b = 8'h2f;  // /
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h61) && (b <= 8'h66)) ||
           ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  // Nibble value of a hex digit; letters sit at 1..6 in their low nibble.
  function automatic logic [3:0] hex_nib(input logic [7:0] b);
    logic [3:0] n;
    if (b <= 8'h39) begin
      n = b[3:0];
    end else begin
      n = b[3:0] + 4'd9;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/file_uri_percent_decoder_core.sv
// A request passes through the queue and then the back part's output register.
// Throughput: one request per cycle while each request yields at most one result and the output is not stalled.
// A request that yields k results (k up to 7) holds the back part until all k are emitted.
// The back part emits one result per cycle while the output is not stalled; the two-entry queue sets the input stall.
// Reset clears the queue and output valid and restarts the "file://" compare.
`default_nettype none
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// File URI percent decoder core
// Strips a leading "file://" and decodes %XX escapes, one byte per request.
// ----------------------------------------------------------------------------
module file_uri_percent_decoder_core import fud_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            out_last_o
);

  logic    accept;
  logic    q_push;
  logic    q_pop;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;

  // Take a request whenever the queue has room.
  assign in_ready_o = !q_stat.full;
  assign accept     = in_valid_i && in_ready_o;

  fud_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (q_push),
    .cmd_o     (front_cmd)
  );

  fud_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  fud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .stat_i      (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o)
  );

  // The queue is never written while full nor read while empty.
  `ASSERT_IMPLY(a_push_room, q_push, !q_stat.full, "queue push while full")
  `ASSERT_IMPLY(a_pop_data, q_pop, !q_stat.empty, "queue pop while empty")

  // An empty marker only closes a string and carries a zero byte.
  `ASSERT_IMPLY(a_marker_last, out_valid_o && !has_byte_o, out_last_o,
                "empty marker without end flag")
  `ASSERT_IMPLY(a_marker_zero, out_valid_o && !has_byte_o, out_byte_o == 8'h00,
                "empty marker with nonzero byte")

endmodule

`default_nettype wire

FILE: hdl/fud_front.sv
// ----------------------------------------------------------------------------
// Decoder front part
// Tracks the prefix match and the pending escape, and turns each accepted
// request that releases bytes or ends a string into one back-part command.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_front import fud_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  logic       prefix_phase_q, prefix_phase_d;
  logic [2:0] prefix_matched_q, prefix_matched_d;
  logic [7:0] held_q, held_d;          // byte after a held '%'
  logic [1:0] held_count_q, held_count_d;

  // Classify the byte and collect the bytes it releases.
  always_comb begin
    logic [1:0] tcnt;
    logic [7:0] c;
    logic [2:0] m;
    logic       decode;

    prefix_phase_d   = prefix_phase_q;
    prefix_matched_d = prefix_matched_q;
    held_d           = held_q;
    held_count_d     = held_count_q;
    cmd_o            = '0;
    tcnt             = 2'd0;
    c                = in_byte_i;
    m                = prefix_matched_q;
    decode           = 1'b0;

    if (prefix_phase_q) begin
      if (c == prefix_byte(m)) begin
        if (m == 3'(PrefixLen - 1)) begin
          prefix_phase_d   = 1'b0;
          prefix_matched_d = 3'd0;
        end else if (in_last_i) begin
          cmd_o.pfx_cnt    = m + 3'd1;
        end else begin
          prefix_matched_d = m + 3'd1;
        end
      end else begin
        // Mismatch: replay the matched part, then decode this byte.
        cmd_o.pfx_cnt    = m;
        prefix_phase_d   = 1'b0;
        prefix_matched_d = 3'd0;
        decode           = 1'b1;
      end
    end else begin
      decode = 1'b1;
    end

    if (decode) begin
      unique case (held_count_q)
        2'd0: begin
          if (c == PctChar) begin
            held_count_d = 2'd1;
          end else begin
            cmd_o.tail[tcnt] = c;
            tcnt = tcnt + 2'd1;
          end
        end
        2'd1: begin
          held_d       = c;
          held_count_d = 2'd2;
        end
        default: begin
          if (is_hex(held_q) && is_hex(c)) begin
            cmd_o.tail[tcnt] = {hex_nib(held_q), hex_nib(c)};
            tcnt = tcnt + 2'd1;
            held_count_d = 2'd0;
          end else begin
            // Bad escape: send the '%' and rescan the two bytes after it.
            cmd_o.tail[tcnt] = PctChar;
            tcnt = tcnt + 2'd1;
            if (held_q == PctChar) begin
              held_d       = c;
              held_count_d = 2'd2;
            end else begin
              cmd_o.tail[tcnt] = held_q;
              tcnt = tcnt + 2'd1;
              if (c == PctChar) begin
                held_count_d = 2'd1;
              end else begin
                cmd_o.tail[tcnt] = c;
                tcnt = tcnt + 2'd1;
                held_count_d = 2'd0;
              end
            end
          end
        end
      endcase
    end

    // End of string: flush held bytes and restart the prefix compare.
    if (in_last_i) begin
      if (held_count_d != 2'd0) begin
        cmd_o.tail[tcnt] = PctChar;
        tcnt = tcnt + 2'd1;
      end
      if (held_count_d == 2'd2) begin
        cmd_o.tail[tcnt] = held_d;
        tcnt = tcnt + 2'd1;
      end
      prefix_phase_d   = 1'b1;
      prefix_matched_d = 3'd0;
      held_count_d     = 2'd0;
    end

    cmd_o.tail_cnt = tcnt;
    cmd_o.last     = in_last_i;
    push_o = accept_i && (in_last_i || (tcnt != 2'd0) || (cmd_o.pfx_cnt != 3'd0));
  end

  // Decoder state, updated on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_phase_q   <= 1'b1;
      prefix_matched_q <= 3'd0;
      held_count_q     <= 2'd0;
    end else if (accept_i) begin
      prefix_phase_q   <= prefix_phase_d;
      prefix_matched_q <= prefix_matched_d;
      held_count_q     <= held_count_d;
    end
  end

  // Held byte payload.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fud_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue that lets the front and back parts stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_queue import fud_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire cmd_t    push_cmd_i,
  input  wire logic    pop_i,
  output cmd_t         head_o,
  output q_stat_t      stat_o
);

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

FILE: hdl/fud_back.sv
// ----------------------------------------------------------------------------
// Decoder back part
// Expands the head command into result bytes, one per cycle while the queue
// holds a command and the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fud_back import fud_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       head_i,
  input  wire q_stat_t    stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            out_last_o
);

  logic [2:0] pos_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       has_byte_q;
  logic       out_last_q;

  logic [3:0] total;
  logic       advance;
  logic       marker;
  logic       final_res;
  logic [1:0] tail_off;
  logic [7:0] res_byte;

  // Pick the result byte at the current position of the head command.
  always_comb begin
    total     = {1'b0, head_i.pfx_cnt} + {2'b00, head_i.tail_cnt};
    marker    = (total == 4'd0);
    final_res = marker || ({1'b0, pos_q} == (total - 4'd1));
    tail_off  = 2'(pos_q - head_i.pfx_cnt);
    if (marker) begin
      res_byte = 8'h00;
    end else if (pos_q < head_i.pfx_cnt) begin
      res_byte = prefix_byte(pos_q);
    end else begin
      res_byte = head_i.tail[tail_off];
    end
    advance = !stat_i.empty && (!out_valid_q || out_ready_i);
    pop_o   = advance && final_res;
  end

  // Position counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        pos_q       <= final_res ? 3'd0 : pos_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= res_byte;
      has_byte_q <= !marker;
      out_last_q <= head_i.last && final_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign has_byte_o  = has_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire
